### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define BSML_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BSML_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bsml_pkg.sv
`default_nettype none

package bsml_pkg;

  localparam int unsigned HEADER_BYTES = 2048;
  localparam int unsigned HDR_IDX_W = (HEADER_BYTES > 2) ? $clog2(HEADER_BYTES) : 1;

  localparam logic [7:0] BYTE_EXE  = 8'h63;
  localparam logic [7:0] BYTE_RAW  = 8'h64;
  localparam logic [7:0] BYTE_CTRL = 8'h62;

  localparam logic [2:0] K_WRITE  = 3'd0;
  localparam logic [2:0] K_HEADER = 3'd1;
  localparam logic [2:0] K_EXEC   = 3'd2;
  localparam logic [2:0] K_DONE   = 3'd3;
  localparam logic [2:0] K_CTRL   = 3'd4;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_EXE,
    CMD_RAW,
    CMD_CTRL
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_ENTRY,
    PH_ADDR,
    PH_LEN,
    PH_PAYLOAD,
    PH_CTRL,
    PH_FINISH
  } phase_t;

  // One classified word waiting between the front and the back.
  typedef struct packed {
    logic [7:0] rx_byte;
    cmd_t       cmd;
  } rx_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [7:0]  value;
  } result_t;

  // Places a byte into a little-endian word; byte zero starts a fresh word.
  function automatic logic [31:0] put_byte(input logic [31:0] word,
                                           input logic [1:0]  idx,
                                           input logic [7:0]  b);
    logic [31:0] base;
    base = (idx == 2'd0) ? 32'd0 : word;
    return base | (32'(b) << {idx, 3'b000});
  endfunction

endpackage

`default_nettype wire

### sv/bsml_front.sv
`default_nettype none

module bsml_front
  import bsml_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire logic     [7:0] in_rx_byte,
  output logic          in_full,
  output logic          q_valid,
  output rx_word_t      q_word,
  input  wire logic     q_take
);

  rx_word_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push_ok;
  logic       pop_ok;
  rx_word_t   word_in;

  always_comb begin
    word_in.rx_byte = in_rx_byte;
    if (in_rx_byte == BYTE_EXE) begin
      word_in.cmd = CMD_EXE;
    end else if (in_rx_byte == BYTE_RAW) begin
      word_in.cmd = CMD_RAW;
    end else if (in_rx_byte == BYTE_CTRL) begin
      word_in.cmd = CMD_CTRL;
    end else begin
      word_in.cmd = CMD_NONE;
    end
  end

  assign in_full = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_word  = mem_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_take && q_valid;

  assign wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
  assign count_nxt  = count_r + {1'b0, push_ok} - {1'b0, pop_ok};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= word_in;
    end
  end

endmodule

`default_nettype wire

### sv/bsml_back.sv
`default_nettype none

module bsml_back
  import bsml_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire rx_word_t q_word,
  output logic          q_take,
  output logic          out_empty,
  input  wire logic     out_pop,
  output logic [2:0]    out_kind,
  output logic [31:0]   out_address,
  output logic [7:0]    out_value
);

  phase_t               phase_r, phase_nxt;
  logic                 is_exe_r, is_exe_nxt;
  logic [HDR_IDX_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]           shift_r, shift_nxt;
  logic [31:0]          entry_r, entry_nxt;
  logic [31:0]          dest_r, dest_nxt;
  logic [31:0]          remain_r, remain_nxt;

  result_t              res_mem_r [2];
  logic                 res_wr_r, res_rd_r;
  logic [1:0]           res_count_r;
  logic                 res_vld;
  result_t              res;
  logic                 res_push;
  logic                 res_pop;

  logic                 hdr_last;
  logic                 word_last;
  logic [31:0]          word_new;
  logic [7:0]           b;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

  assign b         = q_word.rx_byte;
  assign q_take    = q_valid && (res_count_r != 2'd2);
  assign hdr_last  = (cnt_r == HDR_LAST);
  assign word_last = (shift_r == 2'd3);

  // The word under assembly depends on the phase; only one is open at a time.
  always_comb begin
    unique case (phase_r)
      PH_ENTRY: word_new = put_byte(entry_r, shift_r, b);
      PH_ADDR:  word_new = put_byte(dest_r, shift_r, b);
      default:  word_new = put_byte(remain_r, shift_r, b);
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    if (q_take) begin
      unique case (phase_r)
        PH_HEADER:  phase_nxt = hdr_last ? PH_ENTRY : PH_HEADER;
        PH_ENTRY:   phase_nxt = word_last ? PH_ADDR : PH_ENTRY;
        PH_ADDR:    phase_nxt = word_last ? PH_LEN : PH_ADDR;
        PH_LEN: begin
          if (word_last) begin
            phase_nxt = (word_new == 32'd0) ? PH_IDLE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: phase_nxt = (remain_r == 32'd1) ? PH_FINISH : PH_PAYLOAD;
        PH_CTRL:    phase_nxt = PH_IDLE;
        PH_IDLE, PH_FINISH: begin
          unique case (q_word.cmd)
            CMD_EXE:  phase_nxt = PH_HEADER;
            CMD_RAW:  phase_nxt = PH_ADDR;
            CMD_CTRL: phase_nxt = PH_CTRL;
            CMD_NONE: phase_nxt = PH_IDLE;
          endcase
        end
      endcase
    end
  end

  always_comb begin
    res_vld    = 1'b0;
    res        = '0;
    is_exe_nxt = is_exe_r;
    cnt_nxt    = cnt_r;
    shift_nxt  = shift_r;
    entry_nxt  = entry_r;
    dest_nxt   = dest_r;
    remain_nxt = remain_r;
    if (q_take) begin
      unique case (phase_r)
        PH_HEADER: begin
          res_vld = 1'b1;
          res     = '{kind: K_HEADER, address: 32'(cnt_r), value: b};
          cnt_nxt = hdr_last ? '0 : cnt_r + 1'b1;
          if (hdr_last) begin
            shift_nxt = 2'd0;
          end
        end
        PH_ENTRY: begin
          entry_nxt = word_new;
          shift_nxt = shift_r + 2'd1;
        end
        PH_ADDR: begin
          dest_nxt  = word_new;
          shift_nxt = shift_r + 2'd1;
        end
        PH_LEN: begin
          remain_nxt = word_new;
          shift_nxt  = shift_r + 2'd1;
          if (word_last && (word_new == 32'd0)) begin
            res_vld = 1'b1;
            res     = is_exe_r ? result_t'{kind: K_EXEC, address: entry_r, value: 8'd0}
                               : result_t'{kind: K_DONE, address: 32'd0, value: 8'd0};
          end
        end
        PH_PAYLOAD: begin
          res_vld    = 1'b1;
          res        = '{kind: K_WRITE, address: dest_r, value: b};
          dest_nxt   = dest_r + 32'd1;
          remain_nxt = remain_r - 32'd1;
        end
        PH_CTRL: begin
          res_vld = 1'b1;
          res     = '{kind: K_CTRL, address: 32'd0, value: b};
        end
        PH_IDLE, PH_FINISH: begin
          // The word after a finished load is also parsed as a fresh command.
          if (phase_r == PH_FINISH) begin
            res_vld = 1'b1;
            res     = is_exe_r ? result_t'{kind: K_EXEC, address: entry_r, value: 8'd0}
                               : result_t'{kind: K_DONE, address: 32'd0, value: 8'd0};
          end
          shift_nxt = 2'd0;
          cnt_nxt   = '0;
          if (q_word.cmd == CMD_EXE) begin
            is_exe_nxt = 1'b1;
          end else if (q_word.cmd == CMD_RAW) begin
            is_exe_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      is_exe_r <= 1'b0;
      cnt_r    <= '0;
      shift_r  <= 2'd0;
      entry_r  <= 32'd0;
      dest_r   <= 32'd0;
      remain_r <= 32'd0;
    end else begin
      phase_r  <= phase_nxt;
      is_exe_r <= is_exe_nxt;
      cnt_r    <= cnt_nxt;
      shift_r  <= shift_nxt;
      entry_r  <= entry_nxt;
      dest_r   <= dest_nxt;
      remain_r <= remain_nxt;
    end
  end

  // Two-entry result buffer toward the consumer.
  assign res_push    = res_vld;
  assign res_pop     = out_pop && !out_empty;
  assign out_empty   = (res_count_r == 2'd0);
  assign out_kind    = res_mem_r[res_rd_r].kind;
  assign out_address = res_mem_r[res_rd_r].address;
  assign out_value   = res_mem_r[res_rd_r].value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r    <= 1'b0;
      res_rd_r    <= 1'b0;
      res_count_r <= 2'd0;
    end else begin
      res_wr_r    <= res_push ? ~res_wr_r : res_wr_r;
      res_rd_r    <= res_pop ? ~res_rd_r : res_rd_r;
      res_count_r <= res_count_r + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wr_r] <= res;
    end
  end

endmodule

`default_nettype wire

### sv/byte_stream_memory_loader.sv
// A pushed word is registered in the input queue and any result of it in the output queue.
// Throughput: one word per cycle while the output queue is not full, set by the parser.
// Two-entry queues on both sides let input and output stall independently.
// Reset (rst_n low, synchronous) empties both queues and returns the parser to idle
// with all its words cleared.
`default_nettype none

module byte_stream_memory_loader
  import bsml_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_push,
  input  wire logic   [7:0] in_rx_byte,
  output logic        in_full,
  output logic        out_empty,
  input  wire logic   out_pop,
  output logic [2:0]  out_kind,
  output logic [31:0] out_address,
  output logic [7:0]  out_value
);

  logic     q_valid;
  logic     q_take;
  rx_word_t q_word;

  bsml_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .q_valid    (q_valid),
    .q_word     (q_word),
    .q_take     (q_take)
  );

  bsml_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_take      (q_take),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_kind    (out_kind),
    .out_address (out_address),
    .out_value   (out_value)
  );

endmodule

`default_nettype wire

### sv/bsml_checker.sv
`default_nettype none

`include "assert_macros.svh"

module bsml_checker
  import bsml_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [2:0]  out_kind,
  input wire logic [31:0] out_address,
  input wire logic [7:0]  out_value
);

  `BSML_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (out_empty && !in_full), "queues not empty after reset")
  `BSML_ASSERT(a_kind_range, !out_empty |-> (out_kind <= K_CTRL), "result kind out of range")
  `BSML_ASSERT(a_finish_no_value, (!out_empty && (out_kind == K_EXEC || out_kind == K_DONE)) |-> (out_value == 8'd0), "finish word carries data")
  `BSML_ASSERT(a_zero_address, (!out_empty && (out_kind == K_DONE || out_kind == K_CTRL)) |-> (out_address == 32'd0), "done or control word has an address")
  `BSML_ASSERT(a_stall_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_address) && $stable(out_kind)), "waiting word changed")

endmodule

bind byte_stream_memory_loader bsml_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_full     (in_full),
  .out_empty   (out_empty),
  .out_pop     (out_pop),
  .out_kind    (out_kind),
  .out_address (out_address),
  .out_value   (out_value)
);

`default_nettype wire

### tb/tb_byte_stream_memory_loader.sv
`timescale 1ns / 100ps

module tb_byte_stream_memory_loader;
  import bsml_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned QUIET_ITEMS  = 80;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  class loader_predictor;
    phase_t      phase;
    bit          is_exe;
    logic [31:0] hdr_index;
    logic [1:0]  byte_pos;
    logic [31:0] entry_addr;
    logic [31:0] dest_addr;
    logic [31:0] remaining;
    result_t     due_outputs[$];
    int unsigned error_count;
    int unsigned bytes_in;
    int unsigned kind_seen[0:4];

    function new();
      phase = PH_IDLE;
      is_exe = 1'b0;
      hdr_index = '0;
      byte_pos = '0;
      entry_addr = '0;
      dest_addr = '0;
      remaining = '0;
      error_count = 0;
      bytes_in = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void expect_result(logic [2:0] kind, logic [31:0] addr, logic [7:0] value);
      result_t r;
      r.kind = kind;
      r.address = addr;
      r.value = value;
      due_outputs.push_back(r);
    endfunction

    // Little-endian assembly; byte_pos wraps to zero once the word is complete.
    function logic [31:0] merge_le_byte(logic [31:0] word, logic [7:0] b);
      logic [31:0] merged;
      merged = (byte_pos == 2'd0) ? 32'd0 : word;
      merged = merged | (32'(b) << (8 * 32'(byte_pos)));
      byte_pos = byte_pos + 2'd1;
      return merged;
    endfunction

    function void start_command(logic [7:0] b);
      byte_pos = '0;
      hdr_index = '0;
      if (b == BYTE_EXE) begin
        is_exe = 1'b1;
        phase = PH_HEADER;
      end else if (b == BYTE_RAW) begin
        is_exe = 1'b0;
        phase = PH_ADDR;
      end else if (b == BYTE_CTRL) begin
        phase = PH_CTRL;
      end else begin
        phase = PH_IDLE;
      end
    endfunction

    function void finish_load();
      if (is_exe) expect_result(K_EXEC, entry_addr, 8'h00);
      else expect_result(K_DONE, 32'd0, 8'h00);
      phase = PH_IDLE;
    endfunction

    function void note_rx_byte(logic [7:0] b);
      bytes_in++;
      case (phase)
        PH_HEADER: begin
          expect_result(K_HEADER, hdr_index, b);
          hdr_index = hdr_index + 32'd1;
          if (hdr_index >= HEADER_BYTES) begin
            hdr_index = '0;
            byte_pos = '0;
            phase = PH_ENTRY;
          end
        end
        PH_ENTRY: begin
          entry_addr = merge_le_byte(entry_addr, b);
          if (byte_pos == 2'd0) phase = PH_ADDR;
        end
        PH_ADDR: begin
          dest_addr = merge_le_byte(dest_addr, b);
          if (byte_pos == 2'd0) phase = PH_LEN;
        end
        PH_LEN: begin
          remaining = merge_le_byte(remaining, b);
          if (byte_pos == 2'd0) begin
            if (remaining == 32'd0) finish_load();
            else phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          expect_result(K_WRITE, dest_addr, b);
          dest_addr = dest_addr + 32'd1;
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) phase = PH_FINISH;
        end
        PH_CTRL: begin
          expect_result(K_CTRL, 32'd0, b);
          phase = PH_IDLE;
        end
        PH_FINISH: begin
          // The closing result of a load rides on the next word, which then
          // counts as an idle word.
          finish_load();
          start_command(b);
        end
        default: start_command(b);
      endcase
    endfunction

    function void check_result(logic [2:0] kind, logic [31:0] addr, logic [7:0] value);
      result_t want;
      if (due_outputs.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result kind %0d address %h value %h",
                 $time, kind, addr, value);
        return;
      end
      want = due_outputs.pop_front();
      if (want.kind <= K_CTRL) kind_seen[want.kind]++;
      if (kind !== want.kind) begin
        error_count++;
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
      end
      if (addr !== want.address) begin
        error_count++;
        $display("%0t: address expected %h actual %h (kind %0d)",
                 $time, want.address, addr, want.kind);
      end
      if (value !== want.value) begin
        error_count++;
        $display("%0t: value expected %h actual %h (kind %0d)",
                 $time, want.value, value, want.kind);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic [7:0]  in_rx_byte;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  logic [2:0]  out_kind;
  logic [31:0] out_address;
  logic [7:0]  out_value;

  loader_predictor tracker;
  bit              quiet_tail;
  int unsigned     random_count;
  int unsigned     exe_loads_left;
  int unsigned     cycle_count;

  // Noise, control words, a raw load that wraps the address and is closed by a
  // command word, and a raw load of zero length.
  logic [7:0] opening_bytes[$] = '{
    8'h00, 8'hFF, BYTE_CTRL, 8'hFF,
    BYTE_RAW, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'h00, 8'h00,
    8'hAA, 8'h55, 8'h01, BYTE_CTRL, 8'h80,
    BYTE_RAW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  byte_stream_memory_loader uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_rx_byte  (in_rx_byte),
    .in_full     (in_full),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_kind    (out_kind),
    .out_address (out_address),
    .out_value   (out_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_rx_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (!quiet_tail && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    tracker.note_rx_byte(b);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (tracker.due_outputs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_length_byte();
    if (tracker.byte_pos != 2'd0) return 8'h00;
    return ($urandom_range(0, 99) < 15) ? 8'h00 : 8'($urandom_range(1, 10));
  endfunction

  // Mostly well-formed commands with random content; lengths stay small so that
  // loads finish quickly.
  function automatic logic [7:0] pick_stream_byte();
    int unsigned roll;
    logic [7:0]  b;
    roll = $urandom_range(0, 99);
    case (tracker.phase)
      PH_IDLE, PH_FINISH: begin
        if (exe_loads_left != 0 && (roll < 2 || random_count > 300)) begin
          exe_loads_left--;
          return BYTE_EXE;
        end
        if (roll < 45) return BYTE_RAW;
        if (roll < 65) return BYTE_CTRL;
        do b = 8'($urandom); while (b == BYTE_EXE || b == BYTE_RAW);
        return b;
      end
      PH_LEN: return pick_length_byte();
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && !quiet_tail && $urandom_range(0, 4) == 0)
        stall = $urandom_range(1, 6);
      out_pop <= (stall == 0);
      if (stall != 0) stall--;
      @(posedge clk);
      if (rst_n && out_pop && !out_empty)
        tracker.check_result(out_kind, out_address, out_value);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timed out after %0d cycles", $time, cycle_count);
    $display("FAIL byte_stream_memory_loader");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] b;
    bit         counts;
    tracker = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_rx_byte = 8'h00;
    quiet_tail = 1'b0;
    random_count = 0;
    exe_loads_left = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_bytes[i]) send_rx_byte(opening_bytes[i]);
    drain_results();

    // Executable load with all-ones entry and zero length: execute comes at once.
    send_rx_byte(BYTE_EXE);
    for (int i = 0; i < HEADER_BYTES; i++)
      send_rx_byte((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
    repeat (4) send_rx_byte(8'hFF);
    send_rx_byte(8'hF0);
    send_rx_byte(8'hFF);
    send_rx_byte(8'h1F);
    send_rx_byte(8'h80);
    repeat (4) send_rx_byte(8'h00);
    drain_results();

    while (random_count < RANDOM_ITEMS || tracker.phase != PH_IDLE) begin
      b = pick_stream_byte();
      counts = tracker.phase != PH_HEADER &&
               !(tracker.phase == PH_IDLE && b != BYTE_EXE && b != BYTE_RAW &&
                 b != BYTE_CTRL);
      if (counts) random_count++;
      if (random_count >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      send_rx_byte(b);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words, including two executable loads with full headers.",
             tracker.bytes_in);
    $display("Checked %0d writes, %0d header, %0d execute, %0d done, %0d control results.",
             tracker.kind_seen[K_WRITE], tracker.kind_seen[K_HEADER],
             tracker.kind_seen[K_EXEC], tracker.kind_seen[K_DONE],
             tracker.kind_seen[K_CTRL]);
    if (tracker.error_count == 0) begin
      $display("PASS byte_stream_memory_loader");
    end else begin
      $display("FAIL byte_stream_memory_loader");
    end
    $finish;
  end

endmodule
